[rtl/imrg_pkg.sv]
package imrg_pkg;

   localparam int FIELD_BITS        = 64;
   localparam int OPCODE_BITS       = 3;
   localparam int ERROR_BITS        = 2;
   localparam int WORD_BITS_DEFAULT = 64;

   localparam logic [OPCODE_BITS-1:0] OP_MOD = 3'd0;
   localparam logic [OPCODE_BITS-1:0] OP_REM = 3'd1;
   localparam logic [OPCODE_BITS-1:0] OP_XOR = 3'd2;
   localparam logic [OPCODE_BITS-1:0] OP_GCD = 3'd3;
   localparam logic [OPCODE_BITS-1:0] OP_MIN = 3'd4;
   localparam logic [OPCODE_BITS-1:0] OP_MAX = 3'd5;

   localparam logic [ERROR_BITS-1:0] ERR_OK       = 2'd0;
   localparam logic [ERROR_BITS-1:0] ERR_ZERO_DIV = 2'd1;
   localparam logic [ERROR_BITS-1:0] ERR_GCD_OVF  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV,
      ST_AFTER,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic div_init;
      logic div_step;
      logic gcd_swap;
      logic out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_divop;
      logic is_gcd;
      logic b_zero;
      logic gcd_ovf;
      logic y_zero;
      logic div_last;
   } status_type;

endpackage

[rtl/imrg_ctrl.sv]
module imrg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  imrg_pkg::status_type status,
   output imrg_pkg::cmd_type    cmd
);

   imrg_pkg::state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imrg_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         imrg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = imrg_pkg::ST_DECIDE;
            end
         end
         imrg_pkg::ST_DECIDE: begin
            priority if (status.is_divop && !status.b_zero) begin
               cmd.div_init = 1'b1;
               state_in     = imrg_pkg::ST_DIV;
            end else if (status.is_gcd && !status.gcd_ovf && !status.y_zero) begin
               cmd.div_init = 1'b1;
               state_in     = imrg_pkg::ST_DIV;
            end else begin
               state_in = imrg_pkg::ST_FINISH;
            end
         end
         imrg_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = imrg_pkg::ST_AFTER;
            end
         end
         imrg_pkg::ST_AFTER: begin
            // gcd: x <- y, y <- x mod y, then test y again
            if (status.is_gcd) begin
               cmd.gcd_swap = 1'b1;
               state_in     = imrg_pkg::ST_DECIDE;
            end else begin
               state_in = imrg_pkg::ST_FINISH;
            end
         end
         imrg_pkg::ST_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = imrg_pkg::ST_IDLE;
            end
         end
         default: state_in = imrg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

[rtl/imrg_dp.sv]
module imrg_dp #(
   parameter int WORD_BITS = imrg_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  imrg_pkg::cmd_type                       cmd,
   output imrg_pkg::status_type                    status,
   input  logic [imrg_pkg::OPCODE_BITS-1:0]        req_opcode,
   input  logic signed [imrg_pkg::FIELD_BITS-1:0]  req_operand_a,
   input  logic signed [imrg_pkg::FIELD_BITS-1:0]  req_operand_b,
   output logic signed [imrg_pkg::FIELD_BITS-1:0]  rsp_result,
   output logic [imrg_pkg::ERROR_BITS-1:0]         rsp_error_code
);

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [WORD_BITS-1:0] MIN_WORD = {1'b1, {(WORD_BITS-1){1'b0}}};

   logic [imrg_pkg::OPCODE_BITS-1:0] op_ff, op_in;
   logic [WORD_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic [WORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] res_ff, res_in;
   logic [imrg_pkg::ERROR_BITS-1:0] err_ff, err_in;

   logic [WORD_BITS-1:0] a_new, b_new, trial, signed_rem, fin_res;
   logic [imrg_pkg::ERROR_BITS-1:0] fin_err;

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      err_ff <= err_in;
   end

   assign a_new = req_operand_a[WORD_BITS-1:0];
   assign b_new = req_operand_b[WORD_BITS-1:0];
   // remainder stays below the divisor (at most 2^(W-1)), so the shift fits W bits
   assign trial = {rem_ff[WORD_BITS-2:0], quo_ff[WORD_BITS-1]};

   always_comb begin
      op_in  = op_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.capture) begin
         op_in = req_opcode;
         a_in  = a_new;
         b_in  = b_new;
         x_in  = a_new[WORD_BITS-1] ? (~a_new + 1'b1) : a_new;
         y_in  = b_new[WORD_BITS-1] ? (~b_new + 1'b1) : b_new;
      end
      if (cmd.div_init) begin
         rem_in = '0;
         quo_in = x_ff;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = (trial >= y_ff) ? (trial - y_ff) : trial;
         quo_in = {quo_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.gcd_swap) begin
         x_in = y_ff;
         y_in = rem_ff;
      end
   end

   assign status.is_divop = (op_ff == imrg_pkg::OP_MOD) || (op_ff == imrg_pkg::OP_REM);
   assign status.is_gcd   = (op_ff == imrg_pkg::OP_GCD);
   assign status.b_zero   = (b_ff == '0);
   assign status.gcd_ovf  = (a_ff == MIN_WORD) || (b_ff == MIN_WORD);
   assign status.y_zero   = (y_ff == '0);
   assign status.div_last = (cnt_ff == CNT_BITS'(WORD_BITS - 1));

   assign signed_rem = a_ff[WORD_BITS-1] ? (~rem_ff + 1'b1) : rem_ff;

   always_comb begin
      fin_res = '0;
      fin_err = imrg_pkg::ERR_OK;
      unique case (op_ff)
         imrg_pkg::OP_MOD, imrg_pkg::OP_REM: begin
            if (b_ff == '0) begin
               fin_err = imrg_pkg::ERR_ZERO_DIV;
            end else begin
               fin_res = signed_rem;
               // floored: nonzero remainder moves to the divisor's side
               if (op_ff == imrg_pkg::OP_MOD && signed_rem != '0 &&
                   signed_rem[WORD_BITS-1] != b_ff[WORD_BITS-1]) begin
                  fin_res = signed_rem + b_ff;
               end
            end
         end
         imrg_pkg::OP_XOR: fin_res = a_ff ^ b_ff;
         imrg_pkg::OP_GCD: begin
            if (status.gcd_ovf) begin
               fin_err = imrg_pkg::ERR_GCD_OVF;
            end else begin
               fin_res = x_ff;
            end
         end
         imrg_pkg::OP_MIN: fin_res = ($signed(b_ff) < $signed(a_ff)) ? b_ff : a_ff;
         imrg_pkg::OP_MAX: fin_res = ($signed(a_ff) < $signed(b_ff)) ? b_ff : a_ff;
         default: fin_res = '0;
      endcase
   end

   always_comb begin
      res_in = res_ff;
      err_in = err_ff;
      if (cmd.out_load) begin
         res_in = fin_res;
         err_in = fin_err;
      end
   end

   assign rsp_result     = imrg_pkg::FIELD_BITS'($signed(res_ff));
   assign rsp_error_code = err_ff;

endmodule

[rtl/integer_mod_rem_gcd_minmax_unit.sv]
// Integer unit: floored mod, truncated rem, xor, gcd, min and max on signed
// words of WORD_BITS bits (low bits of the 64-bit operand ports).
// Request channel (req_valid/req_ready): one beat carries opcode and the two
// operands. Response channel (rsp_valid/rsp_ready): one beat per request with
// the sign-extended result and an error code (result is zero on error).
// The single radix-2 restoring divider gives one quotient bit per cycle; mod
// and rem run it once, gcd reuses it once per remainder step (Euclid), and
// xor, min, max, a zero divisor and a gcd overflow do not use it. One request
// is in work at a time; req_ready is high only while the unit is idle, so no
// new request is taken until the current result moves to the output register.
// The response sits in an output register, so the next request is taken while
// a finished response still waits; if the receiver stalls and a second result
// is ready, the unit holds it until the output register frees.
// Reset (synchronous, active high) empties the output register and returns the
// controller to idle; datapath registers are not reset.
module integer_mod_rem_gcd_minmax_unit #(
   parameter int WORD_BITS = imrg_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [imrg_pkg::OPCODE_BITS-1:0]        req_opcode,
   input  logic signed [imrg_pkg::FIELD_BITS-1:0]  req_operand_a,
   input  logic signed [imrg_pkg::FIELD_BITS-1:0]  req_operand_b,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [imrg_pkg::FIELD_BITS-1:0]  rsp_result,
   output logic [imrg_pkg::ERROR_BITS-1:0]         rsp_error_code
);

   imrg_pkg::cmd_type    cmd;
   imrg_pkg::status_type status;

   // sequencer: capture, decide, divide, gcd swap, hand result to output reg
   imrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // operand registers, shift-subtract divider, result formatting
   imrg_dp #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_opcode),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .rsp_result     (rsp_result),
      .rsp_error_code (rsp_error_code)
   );

endmodule
